@@ rtl/tfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfp_pkg: shared types and constants of the tuner frequency planner
// Rate table, range limits, status codes and the stage payload structs.
// ----------------------------------------------------------------------------
package tfp_pkg;

   localparam int RATE_SLOTS = 16;

   localparam logic [25:0] SR_MIN_SPS = 26'd100;
   localparam logic [25:0] SR_MAX_SPS = 26'd45000000;
   localparam logic signed [24:0] IF_MIN_KHZ = 25'sd950000;
   localparam logic signed [24:0] IF_MAX_KHZ = 25'sd2150000;
   localparam logic [7:0] FALLBACK_RATE_MHZ = 8'd200;
   localparam logic [22:0] COARSE_OFFSET_KHZ = 23'd40000;
   localparam logic [22:0] COARSE_STEP_KHZ = 23'd10000;

   localparam logic CSR_LNB_LO = 1'b0;
   localparam logic CSR_LNB_UNC = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SR_RANGE = 2'd1,
      STATUS_IF_RANGE = 2'd2
   } status_type;

   function automatic logic [7:0] rate_mhz(input logic [3:0] idx);
      logic [7:0] r;
      case (idx)
         4'd0:    r = 8'd200;
         4'd1:    r = 8'd192;
         4'd2:    r = 8'd193;
         4'd3:    r = 8'd194;
         4'd4:    r = 8'd195;
         4'd5:    r = 8'd196;
         4'd6:    r = 8'd204;
         4'd7:    r = 8'd205;
         4'd8:    r = 8'd206;
         4'd9:    r = 8'd207;
         4'd10:   r = 8'd197;
         4'd11:   r = 8'd198;
         4'd12:   r = 8'd199;
         4'd13:   r = 8'd201;
         4'd14:   r = 8'd202;
         4'd15:   r = 8'd203;
         default: r = FALLBACK_RATE_MHZ;
      endcase
      return r;
   endfunction

   // Quarter of the sample rate in kHz.
   function automatic logic [15:0] step4_khz(input logic [3:0] idx);
      return 16'(rate_mhz(idx)) * 16'd250;
   endfunction

   typedef struct packed {
      status_type                          status;
      logic [25:0]                         sr;
      logic [32:0]                         hw40;
      logic [RATE_SLOTS-1:0][22:0]         rem;
      logic [RATE_SLOTS-1:0][5:0]          quo;
      logic [22:0]                         crem;
      logic [7:0]                          cquo;
   } lane_type;

   typedef struct packed {
      status_type                          status;
      logic [25:0]                         sr;
      logic [7:0]                          cquo;
      logic [15:0]                         fine;
      logic [RATE_SLOTS-1:0]               div4;
      logic [RATE_SLOTS-1:0]               div2;
   } spur_type;

   typedef struct packed {
      status_type                          status;
      logic [7:0]                          adc;
      logic [7:0]                          coarse;
      logic [28:0]                         dsym;
      logic [28:0]                         rsym;
      logic [20:0]                         qsym;
      logic [17:0]                         dfine;
      logic [18:0]                         rfine;
      logic [11:0]                         qfine;
   } div_type;

endpackage

@@ rtl/tfp_channels.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfp_channels: request and response channel interfaces
// Valid/ready channels carrying one tune request or one tune plan per beat.
// ----------------------------------------------------------------------------
interface tfp_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] rf_freq_khz;
   logic [25:0] symbol_rate_sps;
   modport source (output valid, output rf_freq_khz, output symbol_rate_sps, input ready);
   modport sink (input valid, input rf_freq_khz, input symbol_rate_sps, output ready);
endinterface

interface tfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  adc_rate_mhz;
   logic [7:0]  coarse_word;
   logic [15:0] fine_word;
   logic [23:0] symbol_rate_word;
   modport source (output valid, output status, output adc_rate_mhz, output coarse_word,
                   output fine_word, output symbol_rate_word, input ready);
   modport sink (input valid, input status, input adc_rate_mhz, input coarse_word,
                 input fine_word, input symbol_rate_word, output ready);
endinterface

@@ rtl/tfp_prep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfp_prep: first stage
// Forms the IF, checks ranges, builds the band half width and seeds the
// per-rate remainder lanes and the coarse remainder.
// ----------------------------------------------------------------------------
module tfp_prep (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [23:0]       rf_freq_khz,
   input  logic [25:0]       symbol_rate_sps,
   input  logic [23:0]       lnb_lo_khz,
   input  logic [15:0]       lnb_unc_khz,
   output logic              out_valid,
   input  logic              out_ready,
   output tfp_pkg::lane_type out_data
);
   import tfp_pkg::*;

   logic              valid_ff;
   lane_type          data_ff;
   lane_type          data_in;
   logic signed [24:0] if_full;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   assign if_full = $signed({1'b0, rf_freq_khz}) - $signed({1'b0, lnb_lo_khz});

   always_comb begin
      data_in.sr   = symbol_rate_sps;
      data_in.hw40 = 33'(lnb_unc_khz) * 33'd40000 + 33'(symbol_rate_sps) * 33'd27;
      if (symbol_rate_sps < SR_MIN_SPS || symbol_rate_sps > SR_MAX_SPS) begin
         data_in.status = STATUS_SR_RANGE;
      end else if (if_full < IF_MIN_KHZ || if_full > IF_MAX_KHZ) begin
         data_in.status = STATUS_IF_RANGE;
      end else begin
         data_in.status = STATUS_OK;
      end
      for (int i = 0; i < RATE_SLOTS; i++) begin
         data_in.rem[i] = {1'b0, if_full[21:0]};
         data_in.quo[i] = '0;
      end
      data_in.crem = {1'b0, if_full[21:0]} + COARSE_OFFSET_KHZ;
      data_in.cquo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end
endmodule

@@ rtl/tfp_lanes.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfp_lanes: one stage of the constant-divisor lanes
// Retires two quotient bits of IF / (fs/4) per rate lane and up to three
// bits of the coarse 10 MHz division.
// ----------------------------------------------------------------------------
module tfp_lanes #(
   parameter int STAGE = 0,
   parameter int NR    = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tfp_pkg::lane_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output tfp_pkg::lane_type out_data
);
   import tfp_pkg::*;

   logic     valid_ff;
   lane_type data_ff;
   lane_type data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      logic [22:0] trial;
      int          b;
      data_in = in_data;
      for (int i = 0; i < NR; i++) begin
         for (int j = 0; j < 2; j++) begin
            b = 5 - 2 * STAGE - j;
            if (b >= 0) begin
               trial = 23'(step4_khz(4'(i))) << b;
               if (data_in.rem[i] >= trial) begin
                  data_in.rem[i]    = data_in.rem[i] - trial;
                  data_in.quo[i][b] = 1'b1;
               end
            end
         end
      end
      for (int j = 0; j < 3; j++) begin
         b = 7 - 3 * STAGE - j;
         if (b >= 0) begin
            trial = COARSE_STEP_KHZ << b;
            if (data_in.crem >= trial) begin
               data_in.crem    = data_in.crem - trial;
               data_in.cquo[b] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end
endmodule

@@ rtl/tfp_spur.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfp_spur: interferer flag stage
// Turns each lane's remainder into distances to the neighboring fs/4 and
// fs/2 multiples and compares them against the band half width.
// ----------------------------------------------------------------------------
module tfp_spur #(
   parameter int NR = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tfp_pkg::lane_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output tfp_pkg::spur_type out_data
);
   import tfp_pkg::*;

   logic     valid_ff;
   spur_type data_ff;
   spur_type data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      logic [17:0] s4;
      logic [17:0] r4;
      logic [17:0] r2;
      logic [33:0] hw;
      data_in.status = in_data.status;
      data_in.sr     = in_data.sr;
      data_in.cquo   = in_data.cquo;
      data_in.fine   = 16'd40000 - in_data.crem[15:0];
      data_in.div4   = '0;
      data_in.div2   = '0;
      hw = {1'b0, in_data.hw40};
      for (int i = 0; i < NR; i++) begin
         s4 = 18'(step4_khz(4'(i)));
         r4 = in_data.rem[i][17:0];
         // An odd quarter count means the fs/2 grid sits one quarter lower.
         r2 = r4 + (in_data.quo[i][0] ? s4 : 18'd0);
         data_in.div4[i] = (34'(r4) * 34'd40000 < hw) || (34'(s4 - r4) * 34'd40000 < hw);
         data_in.div2[i] = (34'(r2) * 34'd40000 < hw) ||
                           (34'((s4 << 1) - r2) * 34'd40000 < hw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end
endmodule

@@ rtl/tfp_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfp_select: sample rate choice
// Picks the ADC rate from the interferer flags and seeds both dividers.
// ----------------------------------------------------------------------------
module tfp_select #(
   parameter int NR = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tfp_pkg::spur_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output tfp_pkg::div_type  out_data
);
   import tfp_pkg::*;

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      logic       all_hit;
      logic       found;
      logic       ok;
      logic [7:0] fs;
      logic       good;
      all_hit = 1'b1;
      for (int i = 0; i < NR; i++) begin
         all_hit = all_hit && (in_data.div2[i] || in_data.div4[i]);
      end
      found = 1'b0;
      fs    = FALLBACK_RATE_MHZ;
      for (int i = 0; i < NR; i++) begin
         ok = all_hit ? !in_data.div2[i] : !(in_data.div2[i] || in_data.div4[i]);
         if (ok && !found) begin
            found = 1'b1;
            fs    = rate_mhz(4'(i));
         end
      end
      good = (in_data.status == STATUS_OK);
      data_in.status = in_data.status;
      data_in.adc    = good ? fs : 8'd0;
      data_in.coarse = good ? in_data.cquo : 8'd0;
      data_in.dsym   = 29'(fs) * 29'd1000000;
      data_in.dfine  = 18'(fs) * 18'd1000;
      // The upper quotient bits are known to be zero, so the dividers start
      // with the dividend already shifted in.
      data_in.rsym   = good ? {1'b0, in_data.sr, 2'b00} : 29'd0;
      data_in.rfine  = good ? {1'b0, in_data.fine, 2'b00} : 19'd0;
      data_in.qsym   = '0;
      data_in.qfine  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end
endmodule

@@ rtl/tfp_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfp_div: one stage of the restoring dividers
// Retires up to four bits of the symbol-rate quotient and two of the fine quotient.
// ----------------------------------------------------------------------------
module tfp_div #(
   parameter int STAGE = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  tfp_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output tfp_pkg::div_type out_data
);
   import tfp_pkg::*;

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      logic [28:0] rs;
      logic [18:0] rf;
      int          k;
      data_in = in_data;
      for (int j = 0; j < 4; j++) begin
         k = STAGE * 4 + j;
         if (k < 21) begin
            rs = {data_in.rsym[27:0], 1'b0};
            if (rs >= data_in.dsym) begin
               data_in.rsym       = rs - data_in.dsym;
               data_in.qsym[20-k] = 1'b1;
            end else begin
               data_in.rsym = rs;
            end
         end
      end
      for (int j = 0; j < 2; j++) begin
         k = STAGE * 2 + j;
         if (k < 12) begin
            rf = {data_in.rfine[17:0], 1'b0};
            if (rf >= {1'b0, data_in.dfine}) begin
               data_in.rfine       = rf - {1'b0, data_in.dfine};
               data_in.qfine[11-k] = 1'b1;
            end else begin
               data_in.rfine = rf;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end
endmodule

@@ rtl/tuner_frequency_planner_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuner_frequency_planner_core: tune request to ADC rate and tuning words
// Accepts one request beat per cycle unless held off and returns one plan beat
// per request in order, from the prep, lane, spur, select and divider stages.
// Every stage holds its own valid bit, so a stalled response fills bubbles
// behind it before the request side is held off. The depth is set by the
// three constant-divisor lane stages and the six stages of the restoring
// dividers for the symbol-rate and fine words. CSR writes take effect on the
// next request and are to be made while the pipeline is empty.
// ----------------------------------------------------------------------------
module tuner_frequency_planner_core #(
   parameter int NUM_RATES = 10
) (
   input  logic        clock,
   input  logic        reset,
   tfp_req_if.sink     req_bus,
   tfp_rsp_if.source   rsp_bus,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [23:0] csr_wr_data
);
   import tfp_pkg::*;

   localparam int NR = (NUM_RATES > RATE_SLOTS) ? RATE_SLOTS :
                       ((NUM_RATES < 1) ? 1 : NUM_RATES);
   localparam int LANE_STAGES = 3;
   localparam int DIV_STAGES  = 6;

   logic [23:0] lnb_lo_ff;
   logic [15:0] lnb_unc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lnb_lo_ff  <= '0;
         lnb_unc_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LNB_LO:  lnb_lo_ff  <= csr_wr_data;
            CSR_LNB_UNC: lnb_unc_ff <= csr_wr_data[15:0];
            default:     lnb_lo_ff  <= lnb_lo_ff;
         endcase
      end
   end

   logic     lane_valid [LANE_STAGES+1];
   logic     lane_ready [LANE_STAGES+1];
   lane_type lane_data  [LANE_STAGES+1];
   logic     spur_valid;
   logic     spur_ready;
   spur_type spur_data;
   logic     div_valid  [DIV_STAGES+1];
   logic     div_ready  [DIV_STAGES+1];
   div_type  div_data   [DIV_STAGES+1];

   tfp_prep u_prep (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_bus.valid),
      .in_ready        (req_bus.ready),
      .rf_freq_khz     (req_bus.rf_freq_khz),
      .symbol_rate_sps (req_bus.symbol_rate_sps),
      .lnb_lo_khz      (lnb_lo_ff),
      .lnb_unc_khz     (lnb_unc_ff),
      .out_valid       (lane_valid[0]),
      .out_ready       (lane_ready[0]),
      .out_data        (lane_data[0])
   );

   for (genvar s = 0; s < LANE_STAGES; s++) begin : g_lane
      tfp_lanes #(.STAGE(s), .NR(NR)) u_lanes (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (lane_valid[s]),
         .in_ready  (lane_ready[s]),
         .in_data   (lane_data[s]),
         .out_valid (lane_valid[s+1]),
         .out_ready (lane_ready[s+1]),
         .out_data  (lane_data[s+1])
      );
   end

   tfp_spur #(.NR(NR)) u_spur (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lane_valid[LANE_STAGES]),
      .in_ready  (lane_ready[LANE_STAGES]),
      .in_data   (lane_data[LANE_STAGES]),
      .out_valid (spur_valid),
      .out_ready (spur_ready),
      .out_data  (spur_data)
   );

   tfp_select #(.NR(NR)) u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (spur_valid),
      .in_ready  (spur_ready),
      .in_data   (spur_data),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_data  (div_data[0])
   );

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      tfp_div #(.STAGE(s)) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[s]),
         .in_ready  (div_ready[s]),
         .in_data   (div_data[s]),
         .out_valid (div_valid[s+1]),
         .out_ready (div_ready[s+1]),
         .out_data  (div_data[s+1])
      );
   end

   assign rsp_bus.valid            = div_valid[DIV_STAGES];
   assign div_ready[DIV_STAGES]    = rsp_bus.ready;
   assign rsp_bus.status           = div_data[DIV_STAGES].status;
   assign rsp_bus.adc_rate_mhz     = div_data[DIV_STAGES].adc;
   assign rsp_bus.coarse_word      = div_data[DIV_STAGES].coarse;
   assign rsp_bus.fine_word        = {4'd0, div_data[DIV_STAGES].qfine};
   assign rsp_bus.symbol_rate_word = {3'd0, div_data[DIV_STAGES].qsym};

`ifndef SYNTHESIS
   a_rate_in_band: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status == STATUS_OK |->
         rsp_bus.adc_rate_mhz >= 8'd192 && rsp_bus.adc_rate_mhz <= 8'd207)
      else $error("ok plan carries an ADC rate outside 192 to 207 MHz");

   a_error_zeroed: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status != STATUS_OK |->
         rsp_bus.adc_rate_mhz == 8'd0 && rsp_bus.coarse_word == 8'd0 &&
         rsp_bus.fine_word == 16'd0 && rsp_bus.symbol_rate_word == 24'd0)
      else $error("error plan carries nonzero words");

   a_stall_holds_tail: assert property (@(posedge clock) disable iff (reset)
      div_valid[DIV_STAGES-1] && rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid)
      else $error("pipeline tail lost a beat while stalled");
`endif
endmodule
